>>> hdl/btp_pkg.sv
// shared types and constants of the ber-tlv stream parser
// no dependencies; used by btp_level_stack and ber_tlv_stream_parser
`timescale 1ns / 1ps
package btp_pkg;

  localparam int unsigned MAX_DEPTH = 8;
  localparam int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IDX_W     = $clog2(MAX_DEPTH);
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned TAG_W     = 14;
  localparam int unsigned CFG_W     = 4;

  localparam logic [CFG_W-1:0] NEST_LIMIT_RESET = CFG_W'(MAX_DEPTH);

  typedef enum logic [1:0] {
    KIND_PENDING = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_VALUE   = 2'd2,
    KIND_ERROR   = 2'd3
  } byte_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_BAD_LEN = 2'd1,
    ERR_DEEP    = 2'd2,
    ERR_OVERRUN = 2'd3
  } err_code_e;

  // request from the parse logic to the level stack
  typedef struct packed {
    logic               write;
    logic               push;
    logic               len_zero;
    logic [DEPTH_W-1:0] depth;
    logic [LEN_W-1:0]   pos;
    logic [LEN_W-1:0]   end_pos;
  } stk_req_t;

  // what the level stack reports back
  typedef struct packed {
    logic [LEN_W-1:0]   top_end;
    logic [DEPTH_W-1:0] depth_after;
    logic [DEPTH_W-1:0] closed;
  } stk_rsp_t;

endpackage

>>> hdl/ber_tlv_stream_parser.sv
// top level of the ber-tlv stream parser: input register, decode logic, result register
// depends on btp_pkg and btp_level_stack
`timescale 1ns / 1ps
// usage
// - input channel: in_valid_i / in_ready_o carry data_byte_i and frame_start_i, one
//   stream byte per transfer; frame_start_i set clears position, nesting and any
//   latched error before that byte is decoded
// - output channel: out_valid_o / out_ready_i carry exactly one result per byte,
//   in byte order
// - config: cfg_we_i writes cfg_wdata_i into the nesting limit (reset value 8);
//   write it only while no byte is in flight
// - path: a byte accepted into the input register is decoded from there and its result
//   is stored in the result register, which drives the output channel
// - throughput: one byte per cycle while out_ready_i keeps up; the decode is a single
//   pass over the byte held in the input register, and the level stack compares all
//   open end positions in parallel
// - stall: while a result waits on out_ready_i the input register still takes one
//   byte, then in_ready_o drops until the result leaves
// - reset: rst_ni clears the channels, the parse state and sets the limit to 8;
//   the end-position store is not cleared and needs no clearing pass
module ber_tlv_stream_parser
  import btp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_start_i,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         byte_kind_o,
  output logic [1:0]         tag_class_o,
  output logic               is_constructed_o,
  output logic [TAG_W-1:0]   tag_number_o,
  output logic [LEN_W-1:0]   value_length_o,
  output logic [DEPTH_W-1:0] nest_depth_o,
  output logic [7:0]         value_out_o,
  output logic               value_last_o,
  output logic [DEPTH_W-1:0] levels_closed_o,
  output logic [1:0]         error_code_o
);

  localparam logic [2:0] PH_TAG_FIRST  = 3'd0;
  localparam logic [2:0] PH_TAG_SECOND = 3'd1;
  localparam logic [2:0] PH_TAG_THIRD  = 3'd2;
  localparam logic [2:0] PH_LEN_FIRST  = 3'd3;
  localparam logic [2:0] PH_LEN_MORE   = 3'd4;
  localparam logic [2:0] PH_VALUE      = 3'd5;
  localparam logic [2:0] PH_HALT       = 3'd6;

  // input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       fs_q;
  logic       fire;

  // parse state
  logic [CFG_W-1:0]   limit_cfg_q;
  logic [2:0]         phase_q, phase_d;
  logic [TAG_W-1:0]   tag_q, tag_d;
  logic [2:0]         flags_q, flags_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [2:0]         lbl_q, lbl_d;
  logic [LEN_W-1:0]   vbl_q, vbl_d;
  logic [LEN_W-1:0]   pos_q, pos_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [1:0]         err_q, err_d;

  // result register
  logic               out_valid_q;
  logic [1:0]         kind_q, kind_d;
  logic [1:0]         class_q, class_d;
  logic               cons_q, cons_d;
  logic [TAG_W-1:0]   tagn_q, tagn_d;
  logic [LEN_W-1:0]   vlen_q, vlen_d;
  logic [DEPTH_W-1:0] ndep_q, ndep_d;
  logic [7:0]         vout_q, vout_d;
  logic               vlast_q, vlast_d;
  logic [DEPTH_W-1:0] closed_q, closed_d;
  logic [1:0]         ecode_q, ecode_d;

  // frame-cleared view of the state
  logic [2:0]         s_phase;
  logic [TAG_W-1:0]   s_tag;
  logic [2:0]         s_flags;
  logic [LEN_W-1:0]   s_len;
  logic [2:0]         s_lbl;
  logic [LEN_W-1:0]   s_vbl;
  logic [LEN_W-1:0]   s_pos;
  logic [DEPTH_W-1:0] s_depth;
  logic [1:0]         s_err;

  logic [LEN_W-1:0]   pos_new;
  logic [LEN_W:0]     end_pos;
  logic [DEPTH_W-1:0] limit;
  logic               over_end;
  logic               push;
  stk_req_t           stk_req;
  stk_rsp_t           stk_rsp;

  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      fs_q   <= frame_start_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_cfg_q <= NEST_LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_cfg_q <= cfg_wdata_i;
    end
  end

  assign s_phase = fs_q ? PH_TAG_FIRST : phase_q;
  assign s_tag   = fs_q ? '0 : tag_q;
  assign s_flags = fs_q ? '0 : flags_q;
  assign s_len   = fs_q ? '0 : len_q;
  assign s_lbl   = fs_q ? '0 : lbl_q;
  assign s_vbl   = fs_q ? '0 : vbl_q;
  assign s_pos   = fs_q ? '0 : pos_q;
  assign s_depth = fs_q ? '0 : depth_q;
  assign s_err   = fs_q ? '0 : err_q;

  assign pos_new = s_pos + LEN_W'(1);
  assign end_pos = {1'b0, pos_new} + {1'b0, len_d};
  assign limit   = (limit_cfg_q > CFG_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH)
                                                     : DEPTH_W'(limit_cfg_q);
  assign over_end = end_pos[LEN_W] ||
                    ((s_depth != '0) && (end_pos > {1'b0, stk_rsp.top_end}));

  assign stk_req.write    = push && fire;
  assign stk_req.push     = push;
  assign stk_req.len_zero = (len_d == '0);
  assign stk_req.depth    = s_depth;
  assign stk_req.pos      = pos_new;
  assign stk_req.end_pos  = end_pos[LEN_W-1:0];

  btp_level_stack u_stack (
    .clk_i (clk_i),
    .req_i (stk_req),
    .rsp_o (stk_rsp)
  );

  always_comb begin
    logic       done;
    logic       close_req;
    logic [1:0] kind;
    logic [1:0] err;
    logic [2:0] lbl_dec;

    phase_d   = s_phase;
    tag_d     = s_tag;
    flags_d   = s_flags;
    len_d     = s_len;
    lbl_d     = s_lbl;
    vbl_d     = s_vbl;
    pos_d     = pos_new;
    depth_d   = s_depth;
    err_d     = s_err;
    done      = 1'b0;
    close_req = 1'b0;
    push      = 1'b0;
    kind      = KIND_PENDING;
    err       = ERR_NONE;
    lbl_dec   = '0;
    vout_d    = '0;
    vlast_d   = 1'b0;
    closed_d  = '0;

    unique case (s_phase)
      PH_TAG_FIRST: begin
        flags_d = byte_q[7:5];
        len_d   = '0;
        if (byte_q[4:0] != 5'h1F) begin
          tag_d   = TAG_W'(byte_q[4:0]);
          phase_d = PH_LEN_FIRST;
        end else begin
          tag_d   = '0;
          phase_d = PH_TAG_SECOND;
        end
      end
      PH_TAG_SECOND: begin
        tag_d   = {s_tag[TAG_W-8:0], byte_q[6:0]};
        phase_d = byte_q[7] ? PH_TAG_THIRD : PH_LEN_FIRST;
      end
      PH_TAG_THIRD: begin
        tag_d   = {s_tag[TAG_W-8:0], byte_q[6:0]};
        phase_d = PH_LEN_FIRST;
      end
      PH_LEN_FIRST: begin
        if (!byte_q[7]) begin
          len_d = LEN_W'(byte_q);
          done  = 1'b1;
        end else if (byte_q >= 8'h81 && byte_q <= 8'h84) begin
          len_d   = '0;
          lbl_d   = byte_q[2:0];
          phase_d = PH_LEN_MORE;
        end else begin
          err = ERR_BAD_LEN;
        end
      end
      PH_LEN_MORE: begin
        len_d   = {s_len[LEN_W-9:0], byte_q};
        lbl_dec = (s_lbl != '0) ? s_lbl - 3'd1 : '0;
        lbl_d   = lbl_dec;
        done    = (lbl_dec == '0);
      end
      PH_VALUE: begin
        kind   = KIND_VALUE;
        vout_d = byte_q;
        vbl_d  = (s_vbl != '0) ? s_vbl - LEN_W'(1) : '0;
        if (vbl_d == '0) begin
          vlast_d   = 1'b1;
          phase_d   = PH_TAG_FIRST;
          close_req = 1'b1;
        end
      end
      default: begin
        err = s_err;
      end
    endcase

    if (s_phase < PH_HALT && err == ERR_NONE) begin
      if (done) begin
        kind = KIND_HEADER;
        if (flags_d[0]) begin
          if (s_depth >= limit) begin
            err = ERR_DEEP;
          end else if (over_end) begin
            err = ERR_OVERRUN;
          end else begin
            push      = 1'b1;
            phase_d   = PH_TAG_FIRST;
            close_req = 1'b1;
          end
        end else if (over_end) begin
          err = ERR_OVERRUN;
        end else if (len_d == '0) begin
          phase_d   = PH_TAG_FIRST;
          close_req = 1'b1;
        end else begin
          vbl_d   = len_d;
          phase_d = PH_VALUE;
        end
      end else if (kind == KIND_PENDING && s_depth != '0 &&
                   pos_new >= stk_rsp.top_end) begin
        // header still open when the parent ends
        err = ERR_OVERRUN;
      end
    end else if (s_phase >= PH_HALT) begin
      kind = KIND_ERROR;
    end

    if (close_req) begin
      depth_d  = stk_rsp.depth_after;
      closed_d = stk_rsp.closed;
    end

    kind_d  = kind;
    class_d = flags_d[2:1];
    cons_d  = flags_d[0];
    tagn_d  = tag_d;
    vlen_d  = len_d;
    ndep_d  = s_depth;
    ecode_d = ERR_NONE;

    if (err != ERR_NONE || kind == KIND_ERROR) begin
      if (err == ERR_NONE) begin
        err = s_err;
      end
      err_d    = err;
      phase_d  = PH_HALT;
      kind_d   = KIND_ERROR;
      class_d  = '0;
      cons_d   = 1'b0;
      tagn_d   = '0;
      vlen_d   = '0;
      vout_d   = '0;
      vlast_d  = 1'b0;
      closed_d = '0;
      ecode_d  = err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG_FIRST;
      tag_q   <= '0;
      flags_q <= '0;
      len_q   <= '0;
      lbl_q   <= '0;
      vbl_q   <= '0;
      pos_q   <= '0;
      depth_q <= '0;
      err_q   <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      tag_q   <= tag_d;
      flags_q <= flags_d;
      len_q   <= len_d;
      lbl_q   <= lbl_d;
      vbl_q   <= vbl_d;
      pos_q   <= pos_d;
      depth_q <= depth_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      kind_q   <= kind_d;
      class_q  <= class_d;
      cons_q   <= cons_d;
      tagn_q   <= tagn_d;
      vlen_q   <= vlen_d;
      ndep_q   <= ndep_d;
      vout_q   <= vout_d;
      vlast_q  <= vlast_d;
      closed_q <= closed_d;
      ecode_q  <= ecode_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign byte_kind_o      = kind_q;
  assign tag_class_o      = class_q;
  assign is_constructed_o = cons_q;
  assign tag_number_o     = tagn_q;
  assign value_length_o   = vlen_q;
  assign nest_depth_o     = ndep_q;
  assign value_out_o      = vout_q;
  assign value_last_o     = vlast_q;
  assign levels_closed_o  = closed_q;
  assign error_code_o     = ecode_q;

`ifndef SYNTHESIS
  a_err_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_ERROR |-> ecode_q != ERR_NONE)
    else $error("error result without error code");

  a_last_is_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && vlast_q |-> kind_q == KIND_VALUE)
    else $error("value_last on a non-value result");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(MAX_DEPTH))
    else $error("nesting depth beyond stack size");

  a_halt_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HALT |-> err_q != ERR_NONE)
    else $error("halted without a latched error");
`endif

endmodule

>>> hdl/btp_level_stack.sv
// stack of absolute end positions of open constructed elements
// finds how many levels close at the current position; depends on btp_pkg
`timescale 1ns / 1ps
module btp_level_stack
  import btp_pkg::*;
(
  input  logic     clk_i,
  input  stk_req_t req_i,
  output stk_rsp_t rsp_o
);

  logic [LEN_W-1:0]   end_q [MAX_DEPTH];
  logic [DEPTH_W-1:0] top_idx;
  logic [DEPTH_W-1:0] depth_eff;
  logic [DEPTH_W-1:0] keep;
  logic [MAX_DEPTH-1:0] match;

  always_ff @(posedge clk_i) begin
    if (req_i.write) begin
      end_q[req_i.depth[IDX_W-1:0]] <= req_i.end_pos;
    end
  end

  assign top_idx = req_i.depth - DEPTH_W'(1);
  assign rsp_o.top_end = (req_i.depth != '0) ? end_q[top_idx[IDX_W-1:0]] : '0;

  // the entry being pushed ends here exactly when its length is zero
  always_comb begin
    depth_eff = req_i.depth + DEPTH_W'(req_i.push);
    keep      = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (req_i.push && (DEPTH_W'(i) == req_i.depth)) begin
        match[i] = req_i.len_zero;
      end else begin
        match[i] = (end_q[i] == req_i.pos);
      end
      // highest open level that does not end here stays open
      if ((DEPTH_W'(i) < depth_eff) && !match[i]) begin
        keep = DEPTH_W'(i + 1);
      end
    end
  end

  assign rsp_o.depth_after = keep;
  assign rsp_o.closed      = depth_eff - keep;

endmodule
